>>> rtl/core/ksm_pkg.sv
// Shared constants, types and codes of the streaming KMP matcher.
package ksm_pkg;

    localparam int MAX_PATTERN   = 256;
    localparam int POSITION_BITS = 16;
    localparam int SYMBOL_W      = 8;
    localparam int START_W       = 16;
    localparam int LEN_W         = $clog2(MAX_PATTERN + 1);
    localparam int SUB_W         = (LEN_W > POSITION_BITS) ? LEN_W : POSITION_BITS;
    localparam int GROUP_CELLS   = 16;
    localparam int NUM_GROUPS    = (MAX_PATTERN + GROUP_CELLS - 1) / GROUP_CELLS;

    typedef logic [SYMBOL_W-1:0]      sym_t;
    typedef logic [START_W-1:0]       start_t;
    typedef logic [LEN_W-1:0]         len_t;
    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [SUB_W-1:0]         sub_t;

    typedef enum logic [1:0] {
        CMD_APPEND  = 2'd0,
        CMD_TEXT    = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_RESTART = 2'd3
    } command_t;

    typedef enum logic {
        ST_IDLE,
        ST_REDUCE
    } state_t;

    typedef struct packed {
        command_t command;
        sym_t     symbol;
    } in_t;

    typedef struct packed {
        logic   match_found;
        start_t match_start;
        logic   pattern_overflow;
    } out_t;

    typedef struct packed {
        logic fire;
        logic append;
        logic text;
        logic clear;
        logic restart;
        sym_t symbol;
    } cell_op_t;

    typedef struct packed {
        logic valid;
        logic hit;
    } cell_link_t;

endpackage

>>> rtl/core/kmp_stream_matcher_unit.sv
// Top level of the streaming KMP matcher: command decode, counters, reduction, output register.
//
// Input channel (s_valid/s_ready/s_data) carries one command per transaction:
// append a pattern byte, feed a text byte, clear the pattern or restart the
// text position. Every input transaction yields exactly one result
// transaction on the output channel (m_valid/m_ready/m_data): match flag,
// start offset of the completed occurrence, and pattern overflow flag.
// The pattern lives in a row of cells, one byte per cell; each cell keeps the
// flag "the pattern prefix ending here matches the latest text" and updates it
// from its left neighbor on every text byte, so overlapping occurrences are
// all reported.
// Timing: when a transaction is accepted, all cells update and each group
// registers the OR of its cells' match flags; in the REDUCE state this
// two-level reduction ORs the per-group flags into the output register, which
// drives m_valid, once that register is free. No input is taken until then.
// If the receiver stalls, the result waits in the output register; one more
// transaction is accepted, then s_ready stays low until the register frees.
// Reset (aresetn low, synchronous) empties the pattern, zeroes the text
// position and drops any pending result.
module kmp_stream_matcher_unit (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ksm_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output ksm_pkg::out_t m_data
);

    ksm_pkg::state_t   state_reg;
    ksm_pkg::state_t   state_next;
    ksm_pkg::len_t     len_reg;
    ksm_pkg::len_t     len_next;
    ksm_pkg::pos_t     pos_reg;
    ksm_pkg::pos_t     pos_next;
    ksm_pkg::start_t   start_reg;
    ksm_pkg::start_t   start_next;
    logic              ovf_reg;
    logic              ovf_next;
    ksm_pkg::out_t     out_reg;
    logic              m_valid_reg;

    logic              accept;
    logic              full;
    logic              out_free;
    logic              load_out;
    logic              any_match;
    ksm_pkg::sub_t     diff;
    ksm_pkg::start_t   start_calc;
    ksm_pkg::cell_op_t cell_op;

    ksm_pkg::cell_link_t                 glink_out   [ksm_pkg::NUM_GROUPS];
    logic [ksm_pkg::NUM_GROUPS-1:0]      gfirst_valid;
    logic [ksm_pkg::NUM_GROUPS-1:0]      group_match;

    assign accept   = s_valid & s_ready;
    assign full     = (len_reg == ksm_pkg::len_t'(ksm_pkg::MAX_PATTERN));
    assign out_free = ~m_valid_reg | m_ready;

    assign diff = ksm_pkg::sub_t'(pos_reg)
                - ksm_pkg::sub_t'(len_reg - ksm_pkg::len_t'(1));
    assign start_calc = ksm_pkg::start_t'(diff[ksm_pkg::POSITION_BITS-1:0]);

    always_comb begin
        cell_op.fire    = accept;
        cell_op.append  = accept & (s_data.command == ksm_pkg::CMD_APPEND) & ~full;
        cell_op.text    = accept & (s_data.command == ksm_pkg::CMD_TEXT);
        cell_op.clear   = accept & (s_data.command == ksm_pkg::CMD_CLEAR);
        cell_op.restart = accept & (s_data.command == ksm_pkg::CMD_RESTART);
        cell_op.symbol  = s_data.symbol;
    end

    always_comb begin
        len_next   = len_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            ovf_next   = 1'b0;
            start_next = '0;
            case (s_data.command)
                ksm_pkg::CMD_APPEND: begin
                    ovf_next = full;
                    if (!full) begin
                        len_next = len_reg + ksm_pkg::len_t'(1);
                    end
                end
                ksm_pkg::CMD_TEXT: begin
                    start_next = start_calc;
                    pos_next   = pos_reg + ksm_pkg::pos_t'(1);
                end
                ksm_pkg::CMD_CLEAR: begin
                    len_next = '0;
                end
                ksm_pkg::CMD_RESTART: begin
                    pos_next = '0;
                end
                default: begin
                    ovf_next = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ksm_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = ksm_pkg::ST_REDUCE;
                end
            end
            ksm_pkg::ST_REDUCE: begin
                if (out_free) begin
                    state_next = ksm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ksm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ksm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
            end
            ksm_pkg::ST_REDUCE: begin
                load_out = out_free;
            end
            default: begin
                s_ready  = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ksm_pkg::ST_IDLE;
            len_reg     <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        ovf_reg   <= ovf_next;
    end

    assign any_match = |group_match;

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg.match_found      <= any_match;
            out_reg.match_start      <= any_match ? start_reg : '0;
            out_reg.pattern_overflow <= ovf_reg;
        end
    end

    for (genvar g = 0; g < ksm_pkg::NUM_GROUPS; g++) begin : g_group
        logic [ksm_pkg::GROUP_CELLS-1:0] present;
        ksm_pkg::cell_link_t             link_in;
        logic                            next_valid;

        for (genvar c = 0; c < ksm_pkg::GROUP_CELLS; c++) begin : g_present
            assign present[c] = (g * ksm_pkg::GROUP_CELLS + c < ksm_pkg::MAX_PATTERN);
        end

        if (g == 0) begin : g_head
            assign link_in = '{valid: 1'b1, hit: 1'b1};
        end else begin : g_link
            assign link_in = glink_out[g-1];
        end

        if (g == ksm_pkg::NUM_GROUPS - 1) begin : g_last
            assign next_valid = 1'b0;
        end else begin : g_mid
            assign next_valid = gfirst_valid[g+1];
        end

        ksm_cell_group u_group (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .op            (cell_op),
            .link_in       (link_in),
            .next_valid_in (next_valid),
            .present       (present),
            .link_out      (glink_out[g]),
            .first_valid   (gfirst_valid[g]),
            .group_match   (group_match[g])
        );
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.command == ksm_pkg::CMD_CLEAR) |=> (len_reg == '0))
        else $error("pattern length not zero after clear");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= ksm_pkg::len_t'(ksm_pkg::MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input taken while previous transaction still reducing");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(out_reg.match_found && out_reg.pattern_overflow))
        else $error("match and overflow on the same transaction");

    a_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !out_reg.match_found) |-> (out_reg.match_start == '0))
        else $error("start offset set without a match");

    a_tail_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        !glink_out[ksm_pkg::NUM_GROUPS-1].hit)
        else $error("final cell holds a partial match");

endmodule

>>> rtl/core/ksm_cell.sv
// One matcher cell: a pattern byte, its valid flag and its partial-match flag.
module ksm_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  ksm_pkg::cell_op_t   op,
    input  ksm_pkg::cell_link_t link_in,
    input  logic                next_valid,
    input  logic                present,
    output ksm_pkg::cell_link_t link_out,
    output logic                match
);

    ksm_pkg::sym_t sym_reg;
    logic          valid_reg;
    logic          valid_next;
    logic          hit_reg;
    logic          hit_next;
    logic          sym_equal;
    logic          take;

    assign sym_equal = (sym_reg == op.symbol);
    assign take      = op.append & present & link_in.valid & ~valid_reg;

    always_comb begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (op.clear) begin
            valid_next = 1'b0;
            hit_next   = 1'b0;
        end else if (op.restart) begin
            hit_next = 1'b0;
        end else if (take) begin
            valid_next = 1'b1;
        end else if (op.text) begin
            hit_next = valid_reg & next_valid & link_in.hit & sym_equal;
        end
    end

    assign match = op.text & valid_reg & ~next_valid & link_in.hit & sym_equal;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            sym_reg <= op.symbol;
        end
    end

    assign link_out = '{valid: valid_reg, hit: hit_reg};

endmodule

>>> rtl/core/ksm_cell_group.sv
// A segment of matcher cells with its registered match flag.
module ksm_cell_group (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ksm_pkg::cell_op_t                 op,
    input  ksm_pkg::cell_link_t               link_in,
    input  logic                              next_valid_in,
    input  logic [ksm_pkg::GROUP_CELLS-1:0]   present,
    output ksm_pkg::cell_link_t               link_out,
    output logic                              first_valid,
    output logic                              group_match
);

    ksm_pkg::cell_link_t                   links [ksm_pkg::GROUP_CELLS+1];
    logic [ksm_pkg::GROUP_CELLS-1:0]       cell_match;
    logic                                  match_reg;
    logic                                  match_next;

    assign links[0] = link_in;

    for (genvar c = 0; c < ksm_pkg::GROUP_CELLS; c++) begin : g_cell
        logic nv;
        if (c == ksm_pkg::GROUP_CELLS - 1) begin : g_tail
            assign nv = next_valid_in;
        end else begin : g_body
            assign nv = links[c+2].valid;
        end
        ksm_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op         (op),
            .link_in    (links[c]),
            .next_valid (nv),
            .present    (present[c]),
            .link_out   (links[c+1]),
            .match      (cell_match[c])
        );
    end

    assign match_next = op.fire ? (|cell_match) : match_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    assign link_out    = links[ksm_pkg::GROUP_CELLS];
    assign first_valid = links[1].valid;
    assign group_match = match_reg;

endmodule
